FILE: rtl/obac_pkg.sv
package obac_pkg;

  localparam int LEVEL_SLOTS    = 64;
  localparam int ORDER_SLOTS    = 256;
  localparam int PRICE_BITS     = 20;
  localparam int IN_PRICE_BITS  = 20;
  localparam int OUT_PRICE_BITS = 20;
  localparam int ID_BITS        = 64;
  localparam int QTY_BITS       = 32;
  localparam int SUM_BITS       = 40;
  localparam int LVL_IDX_BITS   = $clog2(LEVEL_SLOTS);
  localparam int ORD_IDX_BITS   = $clog2(ORDER_SLOTS);
  localparam int GROUP_SIZE     = 8;
  localparam int GROUPS         = (LEVEL_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;

  typedef logic [PRICE_BITS-1:0]   price_t;
  typedef logic [SUM_BITS-1:0]     sum_t;
  typedef logic [QTY_BITS-1:0]     qty_t;
  typedef logic [ID_BITS-1:0]      id_t;
  typedef logic [LVL_IDX_BITS-1:0] lvl_idx_t;
  typedef logic [ORD_IDX_BITS-1:0] ord_idx_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_ORDER_FULL = 2'd2,
    ST_LEVEL_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_LEVEL,
    S_UPDATE,
    S_BEST1,
    S_BEST2
  } state_t;

  typedef struct packed {
    logic     en;
    lvl_idx_t idx;
    logic     valid;
    price_t   price;
    sum_t     qty;
  } level_wr_t;

  typedef struct packed {
    logic     hit;
    lvl_idx_t hit_idx;
    sum_t     hit_qty;
    logic     free;
    lvl_idx_t free_idx;
  } level_q_t;

  typedef struct packed {
    logic     en;
    ord_idx_t idx;
    logic     valid;
    id_t      id;
    price_t   price;
    qty_t     qty;
    logic     buy;
  } order_wr_t;

  typedef struct packed {
    logic     hit;
    ord_idx_t hit_idx;
    logic     free;
    ord_idx_t free_idx;
    price_t   price;
    qty_t     qty;
    logic     buy;
  } order_q_t;

  typedef struct packed {
    logic   any;
    price_t price;
  } best_t;

  function automatic best_t best_pick(best_t a, best_t b, logic want_high);
    best_t r;
    r = a;
    if (b.any) begin
      if (!a.any) begin
        r = b;
      end else if (want_high ? (b.price > a.price) : (b.price < a.price)) begin
        r = b;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/obac_level_cell.sv
module obac_level_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_sel,
  input  obac_pkg::level_wr_t  wr,
  input  obac_pkg::price_t     query_price,
  input  logic                 free_in,
  output logic                 free_out,
  output logic                 first_free,
  output logic                 match,
  output logic                 valid,
  output obac_pkg::price_t     price,
  output obac_pkg::sum_t       qty
);

  logic             valid_r;
  obac_pkg::price_t price_r;
  obac_pkg::sum_t   qty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_sel) begin
      valid_r <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      price_r <= wr.price;
      qty_r   <= wr.qty;
    end
  end

  // The free flag ripples down the row so that only the lowest empty cell claims.
  assign free_out   = free_in | ~valid_r;
  assign first_free = ~valid_r & ~free_in;
  assign match      = valid_r && (price_r == query_price);
  assign valid      = valid_r;
  assign price      = price_r;
  assign qty        = qty_r;

endmodule

FILE: rtl/obac_level_row.sv
module obac_level_row (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 want_high,
  input  obac_pkg::price_t     query_price,
  input  obac_pkg::level_wr_t  wr,
  output obac_pkg::level_q_t   q,
  output obac_pkg::best_t      best
);

  logic [obac_pkg::LEVEL_SLOTS:0]   free_chain;
  logic [obac_pkg::LEVEL_SLOTS-1:0] first_free;
  logic [obac_pkg::LEVEL_SLOTS-1:0] match;
  logic [obac_pkg::LEVEL_SLOTS-1:0] valid;
  obac_pkg::price_t                 price [obac_pkg::LEVEL_SLOTS];
  obac_pkg::sum_t                   qty   [obac_pkg::LEVEL_SLOTS];
  obac_pkg::best_t                  grp_r   [obac_pkg::GROUPS];
  obac_pkg::best_t                  grp_nxt [obac_pkg::GROUPS];

  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < obac_pkg::LEVEL_SLOTS; i++) begin : g_cell
    obac_level_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .wr_sel      (wr.en && (wr.idx == obac_pkg::LVL_IDX_BITS'(i))),
      .wr          (wr),
      .query_price (query_price),
      .free_in     (free_chain[i]),
      .free_out    (free_chain[i+1]),
      .first_free  (first_free[i]),
      .match       (match[i]),
      .valid       (valid[i]),
      .price       (price[i]),
      .qty         (qty[i])
    );
  end

  // At most one cell matches a price, so the hit fields are an AND-OR select.
  always_comb begin
    q = '0;
    for (int i = 0; i < obac_pkg::LEVEL_SLOTS; i++) begin
      if (match[i]) begin
        q.hit_idx = q.hit_idx | obac_pkg::LVL_IDX_BITS'(i);
        q.hit_qty = q.hit_qty | qty[i];
      end
      if (first_free[i]) begin
        q.free_idx = q.free_idx | obac_pkg::LVL_IDX_BITS'(i);
      end
    end
    q.hit  = |match;
    q.free = free_chain[obac_pkg::LEVEL_SLOTS];
  end

  always_comb begin
    obac_pkg::best_t cand;
    for (int g = 0; g < obac_pkg::GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < obac_pkg::GROUP_SIZE; k++) begin
        if (g * obac_pkg::GROUP_SIZE + k < obac_pkg::LEVEL_SLOTS) begin
          cand.any   = valid[g * obac_pkg::GROUP_SIZE + k];
          cand.price = price[g * obac_pkg::GROUP_SIZE + k];
          grp_nxt[g] = obac_pkg::best_pick(grp_nxt[g], cand, want_high);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < obac_pkg::GROUPS; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    best = '0;
    for (int g = 0; g < obac_pkg::GROUPS; g++) begin
      best = obac_pkg::best_pick(best, grp_r[g], want_high);
    end
  end

endmodule

FILE: rtl/obac_order_cell.sv
module obac_order_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_sel,
  input  obac_pkg::order_wr_t  wr,
  input  obac_pkg::id_t        query_id,
  input  logic                 free_in,
  output logic                 free_out,
  output logic                 first_free,
  output logic                 match,
  output obac_pkg::price_t     price,
  output obac_pkg::qty_t       qty,
  output logic                 buy
);

  logic             valid_r;
  obac_pkg::id_t    id_r;
  obac_pkg::price_t price_r;
  obac_pkg::qty_t   qty_r;
  logic             buy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_sel) begin
      valid_r <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      id_r    <= wr.id;
      price_r <= wr.price;
      qty_r   <= wr.qty;
      buy_r   <= wr.buy;
    end
  end

  assign free_out   = free_in | ~valid_r;
  assign first_free = ~valid_r & ~free_in;
  assign match      = valid_r && (id_r == query_id);
  assign price      = price_r;
  assign qty        = qty_r;
  assign buy        = buy_r;

endmodule

FILE: rtl/order_book_add_cancel_best_unit.sv
// Channel   Ports                                              Direction
// input     in_valid/in_ready, in_kind, in_order_id,           in
//           in_price_tick, in_quantity, in_buy_side
// result    out_valid/out_ready, out_status,                   out
//           out_best_bid_price, out_best_ask_price
//
// After acceptance each transaction steps through the id search across the
// order cells, the price search across the level cells, the update, and the
// registered best-price tree (S_BEST1, S_BEST2) before the result is loaded.
// The input is taken in the idle state. The input is taken again once the
// result register is loaded; a stalled result holds the last step until the
// register frees up.
// Reset clears the valid bit of every cell at once; no clearing pass.
module order_book_add_cancel_best_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_order_id,
  input  logic [19:0] in_price_tick,
  input  logic [31:0] in_quantity,
  input  logic        in_buy_side,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [19:0] out_best_bid_price,
  output logic [19:0] out_best_ask_price
);

  obac_pkg::state_t    state_r, state_nxt;
  logic                kind_r;
  obac_pkg::id_t       id_r;
  obac_pkg::price_t    price_r;
  obac_pkg::qty_t      qty_r;
  logic                buy_r;

  obac_pkg::order_q_t  oq, oq_r;
  obac_pkg::level_q_t  bid_q, ask_q, lq_r;
  logic                side_r, side_nxt;
  obac_pkg::price_t    tgt_price;
  obac_pkg::level_wr_t lwr, bid_wr, ask_wr;
  obac_pkg::order_wr_t owr;
  obac_pkg::best_t     bid_best, ask_best;
  obac_pkg::status_t   status_r, status_nxt;
  logic [obac_pkg::SUM_BITS:0] sum;

  logic                out_valid_r;
  obac_pkg::status_t   out_status_r;
  logic [19:0]         out_bid_r, out_ask_r;
  logic                out_load;

  logic [obac_pkg::ORDER_SLOTS:0]   ofree_chain;
  logic [obac_pkg::ORDER_SLOTS-1:0] ofirst_free;
  logic [obac_pkg::ORDER_SLOTS-1:0] omatch;
  obac_pkg::price_t                 oprice [obac_pkg::ORDER_SLOTS];
  obac_pkg::qty_t                   oqty   [obac_pkg::ORDER_SLOTS];
  logic [obac_pkg::ORDER_SLOTS-1:0] obuy;

  assign in_ready  = (state_r == obac_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status         = out_status_r;
  assign out_best_bid_price = out_bid_r;
  assign out_best_ask_price = out_ask_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      id_r    <= in_order_id;
      price_r <= obac_pkg::PRICE_BITS'(in_price_tick);
      qty_r   <= in_quantity;
      buy_r   <= in_buy_side;
    end
  end

  // Order cells
  assign ofree_chain[0] = 1'b0;

  for (genvar i = 0; i < obac_pkg::ORDER_SLOTS; i++) begin : g_order
    obac_order_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_sel     (owr.en && (owr.idx == obac_pkg::ORD_IDX_BITS'(i))),
      .wr         (owr),
      .query_id   (id_r),
      .free_in    (ofree_chain[i]),
      .free_out   (ofree_chain[i+1]),
      .first_free (ofirst_free[i]),
      .match      (omatch[i]),
      .price      (oprice[i]),
      .qty        (oqty[i]),
      .buy        (obuy[i])
    );
  end

  // Valid ids are unique, so at most one order cell matches.
  always_comb begin
    oq = '0;
    for (int i = 0; i < obac_pkg::ORDER_SLOTS; i++) begin
      if (omatch[i]) begin
        oq.hit_idx = oq.hit_idx | obac_pkg::ORD_IDX_BITS'(i);
        oq.price   = oq.price | oprice[i];
        oq.qty     = oq.qty | oqty[i];
        oq.buy     = oq.buy | obuy[i];
      end
      if (ofirst_free[i]) begin
        oq.free_idx = oq.free_idx | obac_pkg::ORD_IDX_BITS'(i);
      end
    end
    oq.hit  = |omatch;
    oq.free = ofree_chain[obac_pkg::ORDER_SLOTS];
  end

  // Level rows
  assign side_nxt  = (kind_r == obac_pkg::KIND_ADD) ? buy_r : oq_r.buy;
  assign tgt_price = (kind_r == obac_pkg::KIND_ADD) ? price_r : oq_r.price;

  always_comb begin
    bid_wr    = lwr;
    ask_wr    = lwr;
    bid_wr.en = lwr.en & side_r;
    ask_wr.en = lwr.en & ~side_r;
  end

  obac_level_row u_bid (
    .clk         (clk),
    .rst_n       (rst_n),
    .want_high   (1'b1),
    .query_price (tgt_price),
    .wr          (bid_wr),
    .q           (bid_q),
    .best        (bid_best)
  );

  obac_level_row u_ask (
    .clk         (clk),
    .rst_n       (rst_n),
    .want_high   (1'b0),
    .query_price (tgt_price),
    .wr          (ask_wr),
    .q           (ask_q),
    .best        (ask_best)
  );

  always_ff @(posedge clk) begin
    if (state_r == obac_pkg::S_FIND) begin
      oq_r <= oq;
    end
    if (state_r == obac_pkg::S_LEVEL) begin
      side_r <= side_nxt;
      lq_r   <= side_nxt ? bid_q : ask_q;
    end
    if (state_r == obac_pkg::S_UPDATE) begin
      status_r <= status_nxt;
    end
  end

  // Update step: all lookups are registered, so this is one add, or a compare and a subtract.
  always_comb begin
    owr        = '0;
    lwr        = '0;
    status_nxt = obac_pkg::ST_DONE;
    sum        = '0;
    if (state_r == obac_pkg::S_UPDATE) begin
      if (kind_r == obac_pkg::KIND_ADD) begin
        if (!oq_r.hit && !oq_r.free) begin
          status_nxt = obac_pkg::ST_ORDER_FULL;
        end else if (!lq_r.hit && !lq_r.free) begin
          status_nxt = obac_pkg::ST_LEVEL_FULL;
        end else begin
          sum = {1'b0, (lq_r.hit ? lq_r.hit_qty : '0)}
              + (obac_pkg::SUM_BITS + 1)'(qty_r);
          lwr.en    = 1'b1;
          lwr.idx   = lq_r.hit ? lq_r.hit_idx : lq_r.free_idx;
          lwr.valid = 1'b1;
          lwr.price = price_r;
          lwr.qty   = sum[obac_pkg::SUM_BITS] ? '1 : sum[obac_pkg::SUM_BITS-1:0];
          owr.en    = 1'b1;
          owr.idx   = oq_r.hit ? oq_r.hit_idx : oq_r.free_idx;
          owr.valid = 1'b1;
          owr.id    = id_r;
          owr.price = price_r;
          owr.qty   = qty_r;
          owr.buy   = buy_r;
        end
      end else begin
        if (!oq_r.hit) begin
          status_nxt = obac_pkg::ST_NOT_FOUND;
        end else begin
          owr.en    = 1'b1;
          owr.idx   = oq_r.hit_idx;
          owr.valid = 1'b0;
          if (lq_r.hit) begin
            lwr.en    = 1'b1;
            lwr.idx   = lq_r.hit_idx;
            lwr.price = oq_r.price;
            if (lq_r.hit_qty <= obac_pkg::SUM_BITS'(oq_r.qty)) begin
              lwr.valid = 1'b0;
              lwr.qty   = '0;
            end else begin
              lwr.valid = 1'b1;
              lwr.qty   = lq_r.hit_qty - obac_pkg::SUM_BITS'(oq_r.qty);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obac_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      obac_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = obac_pkg::S_FIND;
        end
      end
      obac_pkg::S_FIND:   state_nxt = obac_pkg::S_LEVEL;
      obac_pkg::S_LEVEL:  state_nxt = obac_pkg::S_UPDATE;
      obac_pkg::S_UPDATE: state_nxt = obac_pkg::S_BEST1;
      obac_pkg::S_BEST1:  state_nxt = obac_pkg::S_BEST2;
      obac_pkg::S_BEST2: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = obac_pkg::S_IDLE;
        end
      end
      default: state_nxt = obac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_bid_r    <= bid_best.any ? obac_pkg::OUT_PRICE_BITS'(bid_best.price) : '0;
      out_ask_r    <= ask_best.any ? obac_pkg::OUT_PRICE_BITS'(ask_best.price) : '0;
    end
  end

endmodule

FILE: rtl/obac_checker.sv
module obac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [19:0] out_best_bid_price,
  input logic [19:0] out_best_ask_price
);

  // A new transaction is not taken until the current one has finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // The result of a transaction does not appear while its search and update steps are still running.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid)
                             ##1 !$rose(out_valid))
    else $error("result appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_best_bid_price) && $stable(out_best_ask_price))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind order_book_add_cancel_best_unit obac_checker u_obac_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_best_bid_price (out_best_bid_price),
  .out_best_ask_price (out_best_ask_price)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LVLS = obac_pkg::LEVEL_SLOTS;
  localparam int ORDS = obac_pkg::ORDER_SLOTS;
  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
  localparam int NUM_RANDOM = 850;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic        kind;
    logic [63:0] id;
    logic [19:0] price;
    logic [31:0] qty;
    logic        buy;
    logic        has_exp;
    logic [1:0]  st;
    logic [19:0] bid;
    logic [19:0] ask;
  } row_t;

  typedef struct {
    logic [1:0]  st;
    logic [19:0] bid;
    logic [19:0] ask;
  } book_reply_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_kind = 0;
  logic [63:0] in_order_id = '0;
  logic [19:0] in_price_tick = '0;
  logic [31:0] in_quantity = '0;
  logic        in_buy_side = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [19:0] out_best_bid_price;
  logic [19:0] out_best_ask_price;

  always #10 clk = ~clk;

  order_book_add_cancel_best_unit DUT (.*);

  // Predictor state for both sides' price levels and the order table.
  logic        lv_valid [2][LVLS];
  logic [19:0] lv_price [2][LVLS];
  logic [39:0] lv_sum   [2][LVLS];
  logic        ord_valid [ORDS];
  logic [63:0] ord_id    [ORDS];
  logic [19:0] ord_price [ORDS];
  logic [31:0] ord_qty   [ORDS];
  logic        ord_buy   [ORDS];

  book_reply_t pending_replies[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  logic [63:0] live_ids[$];

  function automatic int level_of(int s, logic [19:0] p);
    for (int i = 0; i < LVLS; i++)
      if (lv_valid[s][i] && lv_price[s][i] == p) return i;
    return -1;
  endfunction

  function automatic int order_of(logic [63:0] id);
    for (int i = 0; i < ORDS; i++)
      if (ord_valid[i] && ord_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [19:0] best_of(int s);
    logic any;
    logic [19:0] b;
    any = 0;
    b = '0;
    for (int i = 0; i < LVLS; i++)
      if (lv_valid[s][i] && (!any || (s == 1 ? lv_price[s][i] > b : lv_price[s][i] < b))) begin
        b = lv_price[s][i];
        any = 1;
      end
    return b;
  endfunction

  function automatic book_reply_t apply_order(logic kind, logic [63:0] id, logic [19:0] p,
                                              logic [31:0] q, logic buy);
    book_reply_t r;
    int slot, lvl, s;
    r.st = obac_pkg::ST_DONE;
    slot = order_of(id);
    if (kind == obac_pkg::KIND_ADD) begin
      s = buy;
      if (slot < 0) begin
        for (int i = ORDS - 1; i >= 0; i--) if (!ord_valid[i]) slot = i;
      end
      lvl = level_of(s, p);
      if (slot < 0) r.st = obac_pkg::ST_ORDER_FULL;
      else if (lvl < 0) begin
        for (int i = LVLS - 1; i >= 0; i--) if (!lv_valid[s][i]) lvl = i;
        if (lvl < 0) r.st = obac_pkg::ST_LEVEL_FULL;
        else begin
          lv_valid[s][lvl] = 1;
          lv_price[s][lvl] = p;
          lv_sum[s][lvl] = '0;
        end
      end
      if (r.st == obac_pkg::ST_DONE) begin
        if (lv_sum[s][lvl] > SUM_MAX - q) lv_sum[s][lvl] = SUM_MAX;
        else lv_sum[s][lvl] += q;
        ord_valid[slot] = 1;
        ord_id[slot] = id;
        ord_price[slot] = p;
        ord_qty[slot] = q;
        ord_buy[slot] = buy;
      end
    end else if (slot < 0) begin
      r.st = obac_pkg::ST_NOT_FOUND;
    end else begin
      s = ord_buy[slot];
      lvl = level_of(s, ord_price[slot]);
      if (lvl >= 0) begin
        if (lv_sum[s][lvl] <= ord_qty[slot]) begin
          lv_valid[s][lvl] = 0;
          lv_sum[s][lvl] = '0;
        end else lv_sum[s][lvl] -= ord_qty[slot];
      end
      ord_valid[slot] = 0;
    end
    r.bid = best_of(1);
    r.ask = best_of(0);
    return r;
  endfunction

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Offers one transaction and waits for its acceptance.
  task automatic offer(row_t r);
    in_valid <= 1;
    in_kind <= r.kind;
    in_order_id <= r.id;
    in_price_tick <= r.price;
    in_quantity <= r.qty;
    in_buy_side <= r.buy;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Predicts on acceptance so the expectation order matches the handshake order.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pending_replies.push_back(apply_order(in_kind, in_order_id, in_price_tick,
                                            in_quantity, in_buy_side));
  end

  always @(posedge clk) begin
    book_reply_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d", out_status);
      end else begin
        e = pending_replies.pop_front();
        if (out_status !== e.st || out_best_bid_price !== e.bid ||
            out_best_ask_price !== e.ask) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d bid=%0d ask=%0d, got st=%0d bid=%0d ask=%0d",
                     e.st, e.bid, e.ask, out_status, out_best_bid_price,
                     out_best_ask_price);
        end
      end
    end
  end

  // Receiver with random stalls, plus one long hold-off timed here once requested.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (hold_req && !hold_done) begin
      out_ready <= 0;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1;
      hold_cnt <= hold_cnt + 1;
    end
    else if (calm) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** order_book_add_cancel_best_unit: FAILED **");
      $finish;
    end
  end

  function automatic row_t mk(logic kind, logic [63:0] id, logic [19:0] p, logic [31:0] q,
                              logic buy);
    row_t r;
    r = '{kind, id, p, q, buy, 1'b0, obac_pkg::ST_DONE, '0, '0};
    return r;
  endfunction

  function automatic row_t mkx(logic kind, logic [63:0] id, logic [19:0] p, logic [31:0] q,
                               logic buy, logic [1:0] st, logic [19:0] bid, logic [19:0] ask);
    row_t r;
    r = '{kind, id, p, q, buy, 1'b1, st, bid, ask};
    return r;
  endfunction

  row_t directed[$];

  initial begin
    row_t r;
    logic [63:0] id;
    int n_long;
    for (int i = 0; i < ORDS; i++) ord_valid[i] = 0;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < LVLS; i++) begin
        lv_valid[s][i] = 0;
        lv_sum[s][i] = '0;
      end
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed rows: extremes, duplicates, zero quantity, unknown cancel.
    directed.push_back(mkx(obac_pkg::KIND_CANCEL, 64'd5, '0, '0, 1'b0,
                           obac_pkg::ST_NOT_FOUND, '0, '0));
    directed.push_back(mkx(obac_pkg::KIND_ADD, '1, 20'hFFFFF, '1, 1'b1,
                           obac_pkg::ST_DONE, 20'hFFFFF, '0));
    directed.push_back(mkx(obac_pkg::KIND_ADD, 64'd0, 20'd0, '1, 1'b0,
                           obac_pkg::ST_DONE, 20'hFFFFF, '0));
    directed.push_back(mk(obac_pkg::KIND_ADD, 64'd1, 20'hFFFFF, '1, 1'b1));
    directed.push_back(mk(obac_pkg::KIND_ADD, 64'd2, 20'hFFFFF, '1, 1'b1));
    directed.push_back(mk(obac_pkg::KIND_ADD, 64'd3, 20'd100, 32'd0, 1'b1));
    directed.push_back(mk(obac_pkg::KIND_ADD, 64'd3, 20'd200, 32'd7, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd3, 20'd5, 32'd9, 1'b1));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd3, '0, '0, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_ADD, 64'd4, 20'h55555, 32'hAAAAAAAA, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, '1, '0, '0, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd1, '0, '0, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd2, '0, '0, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd0, '0, '0, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd4, '0, '0, 1'b0));
    directed.push_back(mk(obac_pkg::KIND_CANCEL, 64'd5, '0, '0, 1'b0));
    foreach (directed[i]) begin
      sender_gap();
      offer(directed[i]);
      // Rows with a typed-in answer cross-check the predictor itself.
      if (directed[i].has_exp) begin
        // Dropping in_valid and waiting on the clock lets the predictor finish the accepted transaction.
        in_valid <= 0;
        @(posedge clk);
        r = directed[i];
        if (pending_replies.size() == 0 ||
            pending_replies[$].st !== r.st || pending_replies[$].bid !== r.bid ||
            pending_replies[$].ask !== r.ask) begin
          errors++;
          if (errors <= 10) $display("directed row %0d: predictor disagrees", i);
        end
      end
    end
    in_valid <= 0;
    wait_drained();

    // Fill the level table on one side to reach the level-full status.
    for (int i = 0; i < LVLS + 2; i++) begin
      offer(mk(obac_pkg::KIND_ADD, 64'h1000 + 64'(i), 20'(1000 + i), 32'd1, 1'b0));
      live_ids.push_back(64'h1000 + 64'(i));
    end
    // Fill the order table to reach the order-full status.
    for (int i = 0; i < ORDS + 2; i++) begin
      offer(mk(obac_pkg::KIND_ADD, 64'h2000 + 64'(i), 20'(500 + (i % 8)), $urandom, 1'b1));
      live_ids.push_back(64'h2000 + 64'(i));
    end
    in_valid <= 0;
    wait_drained();
    foreach (live_ids[i])
      offer(mk(obac_pkg::KIND_CANCEL, live_ids[i], 20'($urandom), $urandom, 1'($urandom)));
    live_ids.delete();
    in_valid <= 0;
    wait_drained();

    // Random part: mostly adds and cancels of live ids in a narrow price band.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) hold_req = 1;
      if (n == 500) begin
        in_valid <= 0;
        wait_drained();
      end
      if (n == NUM_RANDOM - 200) calm = 1;
      sender_gap();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          id = {$urandom, $urandom};
          if ($urandom_range(0, 3) == 0) id = id % 64;
          r = mk(obac_pkg::KIND_ADD, id, 20'(400 + $urandom_range(0, 80)),
                 32'($urandom_range(0, 1000)), 1'($urandom));
          if ($urandom_range(0, 20) == 0) r.qty = $urandom;
          if ($urandom_range(0, 30) == 0) r.price = 20'($urandom);
          if (live_ids.size() < 200) live_ids.push_back(id);
        end
        4, 5, 6, 7: begin
          if (live_ids.size() > 0) begin
            n_long = $urandom_range(0, live_ids.size() - 1);
            id = live_ids[n_long];
            live_ids.delete(n_long);
          end else id = {$urandom, $urandom};
          r = mk(obac_pkg::KIND_CANCEL, id, 20'($urandom), $urandom, 1'($urandom));
        end
        8: r = mk(obac_pkg::KIND_ADD, live_ids.size() > 0 ? live_ids[0] : 64'd9,
                  20'(400 + $urandom_range(0, 80)), 32'($urandom_range(0, 50)),
                  1'($urandom));
        default: r = mk(1'($urandom), {$urandom, $urandom}, 20'($urandom), $urandom,
                        1'($urandom));
      endcase
      offer(r);
    end
    in_valid <= 0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("** order_book_add_cancel_best_unit: PASSED **");
    else $display("** order_book_add_cancel_best_unit: FAILED **");
    $finish;
  end
endmodule
